// ===== rtl/im2col1d_pkg.sv =====
// Shared types and constants for the 1-D im2col address generator.
`timescale 1ns / 1ps

package im2col1d_pkg;

   localparam int SRC_W      = 24;
   localparam int DST_W      = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam int BATCH_W   = 7;
   localparam int LENGTH_W  = 11;
   localparam int CHAN_W    = 9;
   localparam int KERNEL_W  = 5;
   localparam int PAD_W     = 4;
   localparam int STEP_W    = 5;
   localparam int STEP_MAX  = 16;

   localparam int DEF_MAX_BATCH    = 64;
   localparam int DEF_MAX_LENGTH   = 1024;
   localparam int DEF_MAX_CHANNELS = 256;
   localparam int DEF_MAX_KERNEL   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BATCH_COUNT   = 3'd0,
      REG_IN_LENGTH     = 3'd1,
      REG_CHANNEL_COUNT = 3'd2,
      REG_KERNEL_WIDTH  = 3'd3,
      REG_PAD_AMOUNT    = 3'd4,
      REG_STEP_SIZE     = 3'd5,
      REG_OUT_LENGTH    = 3'd6
   } reg_index_type;

   typedef enum logic {
      OUT_EMPTY,
      OUT_FULL
   } out_state_type;

   typedef struct packed {
      logic step;
      logic clear;
   } dp_cmd_type;

endpackage

// ===== rtl/im2col1d_regs.sv =====
// Configuration register file with count clamping.
`timescale 1ns / 1ps

module im2col1d_regs #(
   parameter int MAX_BATCH    = 64,
   parameter int MAX_LENGTH   = 1024,
   parameter int MAX_CHANNELS = 256,
   parameter int MAX_KERNEL   = 16,
   parameter int NBW = $clog2(MAX_BATCH + 1),
   parameter int LW  = $clog2(MAX_LENGTH + 1),
   parameter int CW  = $clog2(MAX_CHANNELS + 1),
   parameter int KW  = $clog2(MAX_KERNEL + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [im2col1d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [im2col1d_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                                write_hit,
   output logic [NBW-1:0]                      nb,
   output logic [LW-1:0]                       len,
   output logic [CW-1:0]                       nch,
   output logic [KW-1:0]                       nk,
   output logic [im2col1d_pkg::PAD_W-1:0]      pad,
   output logic [im2col1d_pkg::STEP_W-1:0]     stp,
   output logic [LW-1:0]                       nout
);
   import im2col1d_pkg::*;

   logic [BATCH_W-1:0]  batch_ff,  batch_in;
   logic [LENGTH_W-1:0] inlen_ff,  inlen_in;
   logic [CHAN_W-1:0]   chan_ff,   chan_in;
   logic [KERNEL_W-1:0] kern_ff,   kern_in;
   logic [PAD_W-1:0]    pad_ff,    pad_in;
   logic [STEP_W-1:0]   step_ff,   step_in;
   logic [LENGTH_W-1:0] outlen_ff, outlen_in;
   logic                wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      batch_in  = batch_ff;
      inlen_in  = inlen_ff;
      chan_in   = chan_ff;
      kern_in   = kern_ff;
      pad_in    = pad_ff;
      step_in   = step_ff;
      outlen_in = outlen_ff;
      write_hit = 1'b0;
      if (wr) begin
         unique case (reg_index_type'(csr_index))
            REG_BATCH_COUNT: begin
               batch_in  = csr_data[BATCH_W-1:0];
               write_hit = 1'b1;
            end
            REG_IN_LENGTH: begin
               inlen_in  = csr_data[LENGTH_W-1:0];
               write_hit = 1'b1;
            end
            REG_CHANNEL_COUNT: begin
               chan_in   = csr_data[CHAN_W-1:0];
               write_hit = 1'b1;
            end
            REG_KERNEL_WIDTH: begin
               kern_in   = csr_data[KERNEL_W-1:0];
               write_hit = 1'b1;
            end
            REG_PAD_AMOUNT: begin
               pad_in    = csr_data[PAD_W-1:0];
               write_hit = 1'b1;
            end
            REG_STEP_SIZE: begin
               step_in   = csr_data[STEP_W-1:0];
               write_hit = 1'b1;
            end
            REG_OUT_LENGTH: begin
               outlen_in = csr_data[LENGTH_W-1:0];
               write_hit = 1'b1;
            end
            default: begin
               write_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff  <= BATCH_W'(1);
         inlen_ff  <= LENGTH_W'(1);
         chan_ff   <= CHAN_W'(1);
         kern_ff   <= KERNEL_W'(1);
         pad_ff    <= '0;
         step_ff   <= STEP_W'(1);
         outlen_ff <= LENGTH_W'(1);
      end else begin
         batch_ff  <= batch_in;
         inlen_ff  <= inlen_in;
         chan_ff   <= chan_in;
         kern_ff   <= kern_in;
         pad_ff    <= pad_in;
         step_ff   <= step_in;
         outlen_ff <= outlen_in;
      end
   end

   // zero acts as one, large values saturate at each maximum; pad is raw
   assign nb   = (batch_ff == '0) ? NBW'(1) :
                 ((32'(batch_ff) > 32'(MAX_BATCH)) ? NBW'(MAX_BATCH) : NBW'(batch_ff));
   assign len  = (inlen_ff == '0) ? LW'(1) :
                 ((32'(inlen_ff) > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : LW'(inlen_ff));
   assign nch  = (chan_ff == '0) ? CW'(1) :
                 ((32'(chan_ff) > 32'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : CW'(chan_ff));
   assign nk   = (kern_ff == '0) ? KW'(1) :
                 ((32'(kern_ff) > 32'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(kern_ff));
   assign pad  = pad_ff;
   assign stp  = (step_ff == '0) ? STEP_W'(1) :
                 ((32'(step_ff) > 32'(STEP_MAX)) ? STEP_W'(STEP_MAX) : step_ff);
   assign nout = (outlen_ff == '0) ? LW'(1) :
                 ((32'(outlen_ff) > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : LW'(outlen_ff));

endmodule

// ===== rtl/im2col1d_ctrl.sv =====
// Handshake controller: output register occupancy and datapath commands.
`timescale 1ns / 1ps

module im2col1d_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     write_hit,
   output im2col1d_pkg::dp_cmd_type cmd
);
   import im2col1d_pkg::*;

   out_state_type state_ff, state_in;
   logic          take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rsp_valid = 1'b0;
      req_stall = 1'b0;
      unique case (state_ff)
         OUT_EMPTY: begin
            rsp_valid = 1'b0;
            req_stall = 1'b0;
         end
         OUT_FULL: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               state_in = OUT_EMPTY;
            end
         end
         default: begin
            state_in = OUT_EMPTY;
         end
      endcase
      take = req_valid & ~req_stall;
      if (take) begin
         state_in = OUT_FULL;
      end
      cmd.step  = take;
      cmd.clear = write_hit;
   end

endmodule

// ===== rtl/im2col1d_dpath.sv =====
// Walk counters, incremental index arithmetic and the output word register.
`timescale 1ns / 1ps

module im2col1d_dpath #(
   parameter int MAX_BATCH    = 64,
   parameter int MAX_LENGTH   = 1024,
   parameter int MAX_CHANNELS = 256,
   parameter int MAX_KERNEL   = 16,
   parameter int NBW = $clog2(MAX_BATCH + 1),
   parameter int LW  = $clog2(MAX_LENGTH + 1),
   parameter int CW  = $clog2(MAX_CHANNELS + 1),
   parameter int KW  = $clog2(MAX_KERNEL + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  im2col1d_pkg::dp_cmd_type         cmd,
   input  logic                             req_restart,
   input  logic [NBW-1:0]                   nb,
   input  logic [LW-1:0]                    len,
   input  logic [CW-1:0]                    nch,
   input  logic [KW-1:0]                    nk,
   input  logic [im2col1d_pkg::PAD_W-1:0]   pad,
   input  logic [im2col1d_pkg::STEP_W-1:0]  stp,
   input  logic [LW-1:0]                    nout,
   output logic [im2col1d_pkg::SRC_W-1:0]   rsp_source_index,
   output logic                             rsp_is_padding,
   output logic [im2col1d_pkg::DST_W-1:0]   rsp_dest_index,
   output logic                             rsp_last
);
   import im2col1d_pkg::*;

   localparam int BI = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int OI = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CI = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int KI = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PW = $clog2((MAX_LENGTH - 1) * STEP_MAX + MAX_KERNEL + 1);

   logic [BI-1:0]    b_ff, b_in, b_cur;
   logic [OI-1:0]    o_ff, o_in, o_cur;
   logic [KI-1:0]    k_ff, k_in, k_cur;
   logic [CI-1:0]    c_ff, c_in, c_cur;
   logic [PW-1:0]    cbase_ff, cbase_in, cbase_cur;
   logic [PW-1:0]    pos_ff, pos_in, pos_cur;
   logic [SRC_W-1:0] brow_ff, brow_in, brow_cur;
   logic [SRC_W-1:0] crow_ff, crow_in, crow_cur;
   logic [SRC_W-1:0] row_ff, row_in, row_cur;
   logic [DST_W-1:0] dest_ff, dest_in, dest_cur;
   logic             fresh_ff;

   logic [SRC_W-1:0] src_ff, src_in;
   logic             padq_ff, padq_in;
   logic [DST_W-1:0] dsto_ff;
   logic             last_ff, last_in;

   logic [SRC_W-1:0] stp_nch, len_nch, pad_nch, start_row, brow_next;
   logic             end_c, end_k, end_o, end_b;

   // per-shape increments of the flat source index
   assign stp_nch   = SRC_W'(stp) * SRC_W'(nch);
   assign len_nch   = SRC_W'(len) * SRC_W'(nch);
   assign pad_nch   = SRC_W'(pad) * SRC_W'(nch);
   assign start_row = SRC_W'(0) - pad_nch;

   always_comb begin
      // at the walk start, take the start row from the current shape
      if (req_restart || fresh_ff) begin
         b_cur     = '0;
         o_cur     = '0;
         k_cur     = '0;
         c_cur     = '0;
         cbase_cur = '0;
         pos_cur   = '0;
         brow_cur  = '0;
         crow_cur  = start_row;
         row_cur   = start_row;
         dest_cur  = '0;
      end else begin
         b_cur     = b_ff;
         o_cur     = o_ff;
         k_cur     = k_ff;
         c_cur     = c_ff;
         cbase_cur = cbase_ff;
         pos_cur   = pos_ff;
         brow_cur  = brow_ff;
         crow_cur  = crow_ff;
         row_cur   = row_ff;
         dest_cur  = dest_ff;
      end

      end_c = (32'(c_cur) + 32'd1) >= 32'(nch);
      end_k = (32'(k_cur) + 32'd1) >= 32'(nk);
      end_o = (32'(o_cur) + 32'd1) >= 32'(nout);
      end_b = (32'(b_cur) + 32'd1) >= 32'(nb);

      padq_in = (32'(pos_cur) < 32'(pad)) || (32'(pos_cur) >= (32'(pad) + 32'(len)));
      src_in  = padq_in ? '0 : (row_cur + SRC_W'(c_cur));
      last_in = end_c & end_k & end_o & end_b;

      brow_next = brow_cur + len_nch;

      b_in     = b_cur;
      o_in     = o_cur;
      k_in     = k_cur;
      c_in     = c_cur;
      cbase_in = cbase_cur;
      pos_in   = pos_cur;
      brow_in  = brow_cur;
      crow_in  = crow_cur;
      row_in   = row_cur;
      dest_in  = dest_cur + DST_W'(1);

      if (last_in) begin
         // wrap to the first element
         b_in     = '0;
         o_in     = '0;
         k_in     = '0;
         c_in     = '0;
         cbase_in = '0;
         pos_in   = '0;
         brow_in  = '0;
         crow_in  = start_row;
         row_in   = start_row;
         dest_in  = '0;
      end else if (!end_c) begin
         c_in = CI'(32'(c_cur) + 32'd1);
      end else if (!end_k) begin
         c_in   = '0;
         k_in   = KI'(32'(k_cur) + 32'd1);
         pos_in = pos_cur + PW'(1);
         row_in = row_cur + SRC_W'(nch);
      end else if (!end_o) begin
         c_in     = '0;
         k_in     = '0;
         o_in     = OI'(32'(o_cur) + 32'd1);
         cbase_in = cbase_cur + PW'(stp);
         pos_in   = cbase_cur + PW'(stp);
         crow_in  = crow_cur + stp_nch;
         row_in   = crow_cur + stp_nch;
      end else begin
         c_in     = '0;
         k_in     = '0;
         o_in     = '0;
         b_in     = BI'(32'(b_cur) + 32'd1);
         cbase_in = '0;
         pos_in   = '0;
         brow_in  = brow_next;
         crow_in  = brow_next - pad_nch;
         row_in   = brow_next - pad_nch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff     <= '0;
         o_ff     <= '0;
         k_ff     <= '0;
         c_ff     <= '0;
         cbase_ff <= '0;
         pos_ff   <= '0;
         brow_ff  <= '0;
         crow_ff  <= '0;
         row_ff   <= '0;
         dest_ff  <= '0;
         fresh_ff <= 1'b1;
      end else if (cmd.clear) begin
         b_ff     <= '0;
         o_ff     <= '0;
         k_ff     <= '0;
         c_ff     <= '0;
         cbase_ff <= '0;
         pos_ff   <= '0;
         brow_ff  <= '0;
         crow_ff  <= '0;
         row_ff   <= '0;
         dest_ff  <= '0;
         fresh_ff <= 1'b1;
      end else if (cmd.step) begin
         b_ff     <= b_in;
         o_ff     <= o_in;
         k_ff     <= k_in;
         c_ff     <= c_in;
         cbase_ff <= cbase_in;
         pos_ff   <= pos_in;
         brow_ff  <= brow_in;
         crow_ff  <= crow_in;
         row_ff   <= row_in;
         dest_ff  <= dest_in;
         fresh_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         src_ff  <= src_in;
         padq_ff <= padq_in;
         dsto_ff <= dest_cur;
         last_ff <= last_in;
      end
   end

   assign rsp_source_index = src_ff;
   assign rsp_is_padding   = padq_ff;
   assign rsp_dest_index   = dsto_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/im2col_1d_address_generator_top.sv =====
// Top level of the 1-D im2col copy schedule generator.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// req_      in         req_valid/stall     req_restart
// rsp_      out        rsp_valid/stall     source_index, is_padding, dest_index, last
// csr_      in         csr_valid/ready     csr_index, csr_data
//
// Every accepted request word yields one response word, registered for the next cycle.
// One word per cycle while rsp_stall is low: the walk counters and the flat source index
// advance by additions only; the shape products feeding them come from the registers.
// Reset is synchronous; it restores the register defaults and puts the walk at its start.
// req_stall rises only while the response register is full and rsp_stall is high.
// A register write resets the walk to its start; user must write only while idle, unchecked.

module im2col_1d_address_generator_top #(
   parameter int MAX_BATCH    = im2col1d_pkg::DEF_MAX_BATCH,
   parameter int MAX_LENGTH   = im2col1d_pkg::DEF_MAX_LENGTH,
   parameter int MAX_CHANNELS = im2col1d_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = im2col1d_pkg::DEF_MAX_KERNEL
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [im2col1d_pkg::SRC_W-1:0]      rsp_source_index,
   output logic                                rsp_is_padding,
   output logic [im2col1d_pkg::DST_W-1:0]      rsp_dest_index,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [im2col1d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [im2col1d_pkg::CSR_DATA_W-1:0] csr_data
);
   import im2col1d_pkg::*;

   localparam int NBW = $clog2(MAX_BATCH + 1);
   localparam int LW  = $clog2(MAX_LENGTH + 1);
   localparam int CW  = $clog2(MAX_CHANNELS + 1);
   localparam int KW  = $clog2(MAX_KERNEL + 1);

   // clamped shape from the register file
   logic [NBW-1:0]    nb;
   logic [LW-1:0]     len;
   logic [CW-1:0]     nch;
   logic [KW-1:0]     nk;
   logic [PAD_W-1:0]  pad;
   logic [STEP_W-1:0] stp;
   logic [LW-1:0]     nout;
   logic              write_hit;
   dp_cmd_type        cmd;

   im2col1d_regs #(
      .MAX_BATCH    (MAX_BATCH),
      .MAX_LENGTH   (MAX_LENGTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL),
      .NBW          (NBW),
      .LW           (LW),
      .CW           (CW),
      .KW           (KW)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .write_hit (write_hit),
      .nb        (nb),
      .len       (len),
      .nch       (nch),
      .nk        (nk),
      .pad       (pad),
      .stp       (stp),
      .nout      (nout)
   );

   // hold the response word while the consumer stalls, advance the walk on accept
   im2col1d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .write_hit (write_hit),
      .cmd       (cmd)
   );

   im2col1d_dpath #(
      .MAX_BATCH    (MAX_BATCH),
      .MAX_LENGTH   (MAX_LENGTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL),
      .NBW          (NBW),
      .LW           (LW),
      .CW           (CW),
      .KW           (KW)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_restart      (req_restart),
      .nb               (nb),
      .len              (len),
      .nch              (nch),
      .nk               (nk),
      .pad              (pad),
      .stp              (stp),
      .nout             (nout),
      .rsp_source_index (rsp_source_index),
      .rsp_is_padding   (rsp_is_padding),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== verif/im2col_1d_walk_checker.sv =====
// Checker that predicts and compares the im2col copy descriptors.
`timescale 1ns / 1ps

module im2col_1d_walk_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_restart,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [im2col1d_pkg::SRC_W-1:0]      rsp_source_index,
   input  logic                                rsp_is_padding,
   input  logic [im2col1d_pkg::DST_W-1:0]      rsp_dest_index,
   input  logic                                rsp_last,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [im2col1d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [im2col1d_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                  mismatches,
   output int                                  outstanding
);
   import im2col1d_pkg::*;

   typedef struct packed {
      logic [SRC_W-1:0] source_index;
      logic             is_padding;
      logic [DST_W-1:0] dest_index;
      logic             last;
   } copy_descriptor_type;

   logic [BATCH_W-1:0]  batch_reg;
   logic [LENGTH_W-1:0] in_len_reg;
   logic [CHAN_W-1:0]   chan_reg;
   logic [KERNEL_W-1:0] kernel_reg;
   logic [PAD_W-1:0]    pad_reg;
   logic [STEP_W-1:0]   step_reg;
   logic [LENGTH_W-1:0] out_len_reg;

   logic [5:0]       batch_pos;
   logic [9:0]       col_pos;
   logic [3:0]       tap_pos;
   logic [7:0]       chan_pos;
   logic [DST_W-1:0] dest_count;

   copy_descriptor_type expected_descriptors[$];
   int                  error_count = 0;

   assign mismatches = error_count;

   // Zero counts act as one; oversized counts saturate.
   function automatic int unsigned effective(int unsigned raw, int unsigned cap);
      if (raw == 0) return 1;
      return (raw > cap) ? cap : raw;
   endfunction

   function void rewind_walk();
      batch_pos  = '0;
      col_pos    = '0;
      tap_pos    = '0;
      chan_pos   = '0;
      dest_count = '0;
   endfunction

   function copy_descriptor_type advance_walk(logic restart);
      int unsigned         nb, len, nch, nk, pad, stp, nout, pos;
      logic                end_ch, end_k, end_o, end_b;
      copy_descriptor_type d;
      nb   = effective(batch_reg, DEF_MAX_BATCH);
      len  = effective(in_len_reg, DEF_MAX_LENGTH);
      nch  = effective(chan_reg, DEF_MAX_CHANNELS);
      nk   = effective(kernel_reg, DEF_MAX_KERNEL);
      pad  = pad_reg;
      stp  = effective(step_reg, STEP_MAX);
      nout = effective(out_len_reg, DEF_MAX_LENGTH);
      if (restart) rewind_walk();
      // column in the padded input
      pos = col_pos * stp + tap_pos;
      d.is_padding = (pos < pad) || (pos - pad >= len);
      d.source_index = d.is_padding ? '0 : SRC_W'((batch_pos * len + pos - pad) * nch + chan_pos);
      d.dest_index = dest_count;
      end_ch = (chan_pos + 1 >= nch);
      end_k  = (tap_pos + 1 >= nk);
      end_o  = (col_pos + 1 >= nout);
      end_b  = (batch_pos + 1 >= nb);
      d.last = end_ch && end_k && end_o && end_b;
      if (d.last) begin
         rewind_walk();
      end else begin
         dest_count = dest_count + 1'b1;
         if (!end_ch) begin
            chan_pos++;
         end else begin
            chan_pos = '0;
            if (!end_k) begin
               tap_pos++;
            end else begin
               tap_pos = '0;
               if (!end_o) begin
                  col_pos++;
               end else begin
                  col_pos = '0;
                  batch_pos++;
               end
            end
         end
      end
      return d;
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      copy_descriptor_type want;
      if (reset) begin
         batch_reg   = 1;
         in_len_reg  = 1;
         chan_reg    = 1;
         kernel_reg  = 1;
         pad_reg     = 0;
         step_reg    = 1;
         out_len_reg = 1;
         rewind_walk();
         expected_descriptors.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BATCH_COUNT:   batch_reg   = csr_data[BATCH_W-1:0];
               REG_IN_LENGTH:     in_len_reg  = csr_data[LENGTH_W-1:0];
               REG_CHANNEL_COUNT: chan_reg    = csr_data[CHAN_W-1:0];
               REG_KERNEL_WIDTH:  kernel_reg  = csr_data[KERNEL_W-1:0];
               REG_PAD_AMOUNT:    pad_reg     = csr_data[PAD_W-1:0];
               REG_STEP_SIZE:     step_reg    = csr_data[STEP_W-1:0];
               REG_OUT_LENGTH:    out_len_reg = csr_data[LENGTH_W-1:0];
               default: ;
            endcase
            // unlisted indexes leave the walk where it is
            if (csr_index <= REG_OUT_LENGTH) rewind_walk();
         end
         if (req_valid && !req_stall) begin
            expected_descriptors.push_back(advance_walk(req_restart));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_descriptors.size() == 0) begin
               error_count++;
               $display("%0t: response word with nothing expected, got src 0x%0h dst 0x%0h",
                        $time, rsp_source_index, rsp_dest_index);
            end else begin
               want = expected_descriptors.pop_front();
               compare_field("source_index", want.source_index, rsp_source_index);
               compare_field("is_padding", want.is_padding, rsp_is_padding);
               compare_field("dest_index", want.dest_index, rsp_dest_index);
               compare_field("last", want.last, rsp_last);
            end
         end
      end
      outstanding <= expected_descriptors.size();
   end

endmodule

// ===== verif/im2col_1d_address_generator_top_tb.sv =====
// Testbench top: stimulus and verdict for the 1-D im2col address generator.
`timescale 1ns / 1ps

module im2col_1d_address_generator_top_tb;
   import im2col1d_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 1650;
   // an index past the register list; writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_UNLISTED = 3'd7;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_restart = 1'b0;
   logic                  rsp_stall   = 1'b0;
   logic                  csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = REG_BATCH_COUNT;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic [SRC_W-1:0]      rsp_source_index;
   logic                  rsp_is_padding;
   logic [DST_W-1:0]      rsp_dest_index;
   logic                  rsp_last;
   logic                  csr_ready;

   int   mismatches;
   int   outstanding;
   int   quiet_cycles = 0;
   logic steady = 1'b0;   // high: neither side idles

   always #4 clock = ~clock;

   im2col_1d_address_generator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_source_index (rsp_source_index),
      .rsp_is_padding   (rsp_is_padding),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   im2col_1d_walk_checker walk_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_source_index (rsp_source_index),
      .rsp_is_padding   (rsp_is_padding),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // Stall the response side at random, odds 31 in 100, except in the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 31);
   end

   // Watchdog: end the run when no channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Send one request word, idling first at random; return once it is taken.
   task automatic push_req(input logic restart);
      while (!steady && $urandom_range(99) < 31) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom_range(1));   // noise while idle
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      // hold the word until the block takes it
      while (req_stall) @(posedge clock);
   endtask

   // Drive one register write and wait for the handshake; the caller drops csr_valid.
   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Drop the request side and wait until every expected response word has arrived.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly small shapes so the walk wraps often; now and then zero or any 11-bit value.
   function automatic logic [CSR_DATA_W-1:0] pick_value(reg_index_type idx);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 15) return CSR_DATA_W'($urandom_range(2047));
      case (idx)
         REG_BATCH_COUNT:   return CSR_DATA_W'($urandom_range(3, 1));
         REG_IN_LENGTH:     return CSR_DATA_W'($urandom_range(10, 1));
         REG_CHANNEL_COUNT: return CSR_DATA_W'($urandom_range(4, 1));
         REG_KERNEL_WIDTH:  return CSR_DATA_W'($urandom_range(4, 1));
         REG_PAD_AMOUNT:    return CSR_DATA_W'($urandom_range(3, 0));
         REG_STEP_SIZE:     return CSR_DATA_W'($urandom_range(3, 1));
         default:           return CSR_DATA_W'($urandom_range(6, 1));
      endcase
   endfunction

   initial begin
      int phase;
      int burst;
      int random_words;
      phase        = 0;
      random_words = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Default shape: a walk of one element, so every word is the last one.
      push_req(1'b0);
      push_req(1'b1);
      push_req(1'b0);

      // Small shape with padding on both sides: 2 batches x 3 columns x 3 taps.
      settle();
      program_reg(REG_BATCH_COUNT, 11'd2);
      program_reg(REG_IN_LENGTH, 11'd3);
      program_reg(REG_CHANNEL_COUNT, 11'd1);
      program_reg(REG_KERNEL_WIDTH, 11'd3);
      program_reg(REG_PAD_AMOUNT, 11'd1);
      program_reg(REG_STEP_SIZE, 11'd1);
      program_reg(REG_OUT_LENGTH, 11'd3);
      csr_valid <= 1'b0;
      repeat (8) push_req(1'b0);
      // An unlisted index must not disturb the walk.
      settle();
      program_reg(REG_UNLISTED, '1);
      csr_valid <= 1'b0;
      repeat (11) push_req(1'b0);   // runs past the last element and wraps
      push_req(1'b1);

      // All registers zero: counts act as one.
      settle();
      for (int r = REG_BATCH_COUNT; r <= REG_OUT_LENGTH; r++) program_reg(CSR_IDX_W'(r), '0);
      csr_valid <= 1'b0;
      push_req(1'b0);
      push_req(1'b1);

      // All data bits set: masked and saturated to the largest shape.
      settle();
      for (int r = REG_BATCH_COUNT; r <= REG_OUT_LENGTH; r++) program_reg(CSR_IDX_W'(r), '1);
      csr_valid <= 1'b0;
      push_req(1'b0);
      push_req(1'b0);

      // Random phases: new shape, then a burst of advance words with rare restarts.
      while (random_words < RANDOM_WORDS) begin
         settle();
         steady = (phase == 6);
         for (int r = REG_BATCH_COUNT; r <= REG_OUT_LENGTH; r++) begin
            if ($urandom_range(99) < 70) begin
               program_reg(CSR_IDX_W'(r), pick_value(reg_index_type'(r)));
            end
         end
         if ($urandom_range(99) < 20) program_reg(REG_UNLISTED, CSR_DATA_W'($urandom_range(2047)));
         csr_valid <= 1'b0;
         burst = steady ? 200 : $urandom_range(90, 20);
         repeat (burst) push_req($urandom_range(99) < 4);
         random_words += burst;
         phase++;
      end

      // Drain, then let the response register show anything stray before the verdict.
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
